### src/vertex_attribute_interpolator_defines.svh
// Assertion helpers shared by the RTL that checks itself.
`ifndef VERTEX_ATTRIBUTE_INTERPOLATOR_DEFINES_SVH
`define VERTEX_ATTRIBUTE_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define VAI_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("vai: assertion failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define VAI_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("vai: assertion failed");

`endif

### src/vai_pkg.sv
package vai_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ACC_W      = 48;
    localparam int MAG_W      = ACC_W;
    // Normalized magnitude lies in [2^SCALE_LO, 2^(SCALE_LO+1))
    localparam int SCALE_LO   = 29;
    localparam int SQ_IN_W    = SCALE_LO + 1;
    localparam int SQ_W       = 2 * SQ_IN_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int ROOT_STEPS = SUM_W / 2;
    localparam int DIV_W      = 32;
    localparam int NUM_W      = ACC_W + FRAC_BITS + SCALE_LO;
    localparam int QUO_W      = NUM_W - SCALE_LO;
    localparam int CNT_W      = $clog2(QUO_W);
    localparam int SH_W       = 7;
    localparam int HALF_W     = MAG_W / 2;
    localparam int PP_W       = HALF_W + DATA_WIDTH;
    localparam int PROD_W     = MAG_W + DATA_WIDTH;

    localparam int IN_TDATA_W  = ((5 * DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((4 * DATA_WIDTH + 7) / 8) * 8;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    localparam logic [1:0] KIND_POS    = 2'd0;
    localparam logic [1:0] KIND_SCREEN = 2'd1;
    localparam logic [1:0] KIND_TEX    = 2'd2;
    localparam logic [1:0] KIND_NORMAL = 2'd3;

    // Lane operations
    localparam logic [3:0] LN_HOLD     = 4'd0;
    localparam logic [3:0] LN_LOAD_IN  = 4'd1;
    localparam logic [3:0] LN_LOAD_ACC = 4'd2;
    localparam logic [3:0] LN_SQ_SHIFT = 4'd3;
    localparam logic [3:0] LN_SQ_MUL   = 4'd4;
    localparam logic [3:0] LN_DIV_INIT = 4'd5;
    localparam logic [3:0] LN_DIV_STEP = 4'd6;
    localparam logic [3:0] LN_DIV_END  = 4'd7;
    localparam logic [3:0] LN_MUL_LO   = 4'd8;
    localparam logic [3:0] LN_MUL_HI   = 4'd9;
    localparam logic [3:0] LN_TERM     = 4'd10;
    localparam logic [3:0] LN_ACC      = 4'd11;
    localparam logic [3:0] LN_CLEAR    = 4'd12;

    // Merge unit operations
    localparam logic [2:0] NM_HOLD  = 3'd0;
    localparam logic [2:0] NM_MAX   = 3'd1;
    localparam logic [2:0] NM_SCALE = 3'd2;
    localparam logic [2:0] NM_SUM   = 3'd3;
    localparam logic [2:0] NM_STEP  = 3'd4;

    typedef struct packed {
        logic [3:0]             op;
        logic signed [SH_W-1:0] shift;
    } t_lane_ctl;

    typedef logic [MAG_W-1:0] t_mag;
    typedef logic [SQ_W-1:0]  t_sq;

    function automatic logic [DATA_WIDTH-1:0] sat_data(input logic signed [ACC_W-1:0] v);
        logic [DATA_WIDTH-1:0] res;
        if (v[ACC_W-1:DATA_WIDTH-1] == '0 || v[ACC_W-1:DATA_WIDTH-1] == '1) begin
            res = v[DATA_WIDTH-1:0];
        end else if (v[ACC_W-1]) begin
            res = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            res = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

### src/vai_lane.sv
module vai_lane (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  vai_pkg::t_lane_ctl                   i_ctl,
    input  logic signed [vai_pkg::DATA_WIDTH-1:0] i_data,
    input  logic signed [vai_pkg::DATA_WIDTH-1:0] i_weight,
    input  logic [vai_pkg::DIV_W-1:0]            i_div,
    output vai_pkg::t_mag                        o_mag,
    output vai_pkg::t_sq                         o_sq,
    output logic signed [vai_pkg::ACC_W-1:0]     o_value
);
    import vai_pkg::*;

    logic signed [ACC_W-1:0]  r_opnd;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  r_term;
    logic [SQ_IN_W-1:0]       r_s;
    logic [SQ_W-1:0]          r_sq;
    logic [DIV_W-1:0]         r_rem;
    logic [QUO_W-1:0]         r_quo;
    logic [PP_W-1:0]          r_plo;
    logic [PP_W-1:0]          r_phi;

    logic [MAG_W-1:0]          w_mag;
    logic [DATA_WIDTH-1:0]     w_wmag;
    logic [SH_W-1:0]           w_neg_sh;
    logic [MAG_W+SCALE_LO-1:0] w_up;
    logic [SQ_IN_W-1:0]        w_s;
    logic [NUM_W-1:0]          w_num;
    logic [DIV_W:0]            w_trial;
    logic                      w_ge;
    logic                      w_big_q;
    logic [PROD_W-1:0]         w_prod;
    logic [PROD_W-1:0]         w_q;
    logic [PROD_W-1:0]         w_qr;
    logic                      w_neg;
    logic                      w_big_p;
    logic signed [ACC_W-1:0]   w_term;
    logic signed [ACC_W:0]     w_sum;
    logic signed [ACC_W-1:0]   w_acc;

    assign w_mag    = r_opnd[ACC_W-1] ? MAG_W'(-r_opnd) : MAG_W'(r_opnd);
    assign w_wmag   = i_weight[DATA_WIDTH-1] ? DATA_WIDTH'(-i_weight) : DATA_WIDTH'(i_weight);
    assign w_neg_sh = SH_W'(-i_ctl.shift);

    // scale the magnitude into the square-root window
    assign w_up = (MAG_W+SCALE_LO)'(w_mag) << i_ctl.shift;
    assign w_s  = i_ctl.shift[SH_W-1] ? SQ_IN_W'(w_mag >> w_neg_sh) : SQ_IN_W'(w_up);

    assign w_num = i_ctl.shift[SH_W-1] ? NUM_W'(w_mag >> w_neg_sh)
                                       : (NUM_W'(w_mag) << i_ctl.shift);

    assign w_trial = {r_rem, r_quo[QUO_W-1]};
    assign w_ge    = w_trial >= {1'b0, i_div};
    assign w_big_q = |r_quo[QUO_W-1:ACC_W-1];

    // product, floor shift, saturate
    assign w_prod  = {r_phi, {HALF_W{1'b0}}} + PROD_W'(r_plo);
    assign w_q     = w_prod >> FRAC_BITS;
    assign w_neg   = r_opnd[ACC_W-1] ^ i_weight[DATA_WIDTH-1];
    assign w_qr    = w_q + PROD_W'(w_neg && (w_prod[FRAC_BITS-1:0] != '0));
    assign w_big_p = |w_qr[PROD_W-1:ACC_W-1];
    assign w_term  = w_neg ? (w_big_p ? ACC_MIN : -ACC_W'(w_qr))
                           : (w_big_p ? ACC_MAX : ACC_W'(w_qr));

    assign w_sum = {r_acc[ACC_W-1], r_acc} + {r_term[ACC_W-1], r_term};
    assign w_acc = (w_sum[ACC_W] != w_sum[ACC_W-1])
                 ? (w_sum[ACC_W] ? ACC_MIN : ACC_MAX) : w_sum[ACC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.op == LN_ACC) begin
            r_acc <= w_acc;
        end else if (i_ctl.op == LN_CLEAR) begin
            r_acc <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            LN_LOAD_IN: begin
                r_opnd <= {{(ACC_W-DATA_WIDTH){i_data[DATA_WIDTH-1]}}, i_data};
            end
            LN_LOAD_ACC: begin
                r_opnd <= r_acc;
            end
            LN_SQ_SHIFT: begin
                r_s <= w_s;
            end
            LN_SQ_MUL: begin
                r_sq <= r_s * r_s;
            end
            LN_DIV_INIT: begin
                r_rem <= DIV_W'(w_num >> QUO_W);
                r_quo <= w_num[QUO_W-1:0];
            end
            LN_DIV_STEP: begin
                r_rem <= w_ge ? DIV_W'(w_trial - {1'b0, i_div}) : DIV_W'(w_trial);
                r_quo <= {r_quo[QUO_W-2:0], w_ge};
            end
            LN_DIV_END: begin
                if (r_opnd[ACC_W-1]) begin
                    r_opnd <= w_big_q ? ACC_MIN : -ACC_W'(r_quo);
                end else begin
                    r_opnd <= w_big_q ? ACC_MAX : ACC_W'(r_quo);
                end
            end
            LN_MUL_LO: begin
                r_plo <= w_mag[HALF_W-1:0] * w_wmag;
            end
            LN_MUL_HI: begin
                r_phi <= w_mag[MAG_W-1:HALF_W] * w_wmag;
            end
            LN_TERM: begin
                r_term <= w_term;
            end
            default: begin
            end
        endcase
    end

    assign o_mag   = w_mag;
    assign o_sq    = r_sq;
    assign o_value = r_opnd;

endmodule

### src/vai_norm.sv
module vai_norm (
    input  logic                            i_clk,
    input  logic [2:0]                      i_op,
    input  logic [2:0][vai_pkg::MAG_W-1:0]  i_mag,
    input  logic [2:0][vai_pkg::SQ_W-1:0]   i_sq,
    output logic                            o_zero,
    output logic                            o_scaled,
    output logic signed [vai_pkg::SH_W-1:0] o_p,
    output logic [vai_pkg::DIV_W-1:0]       o_root
);
    import vai_pkg::*;

    logic [MAG_W-1:0]       r_m;
    logic signed [SH_W-1:0] r_p;
    logic [SUM_W-1:0]       r_rad;
    logic [SUM_W-1:0]       r_root;
    logic [SUM_W-1:0]       r_bit;

    logic [MAG_W-1:0] w_m01;
    logic [MAG_W-1:0] w_max;
    logic             w_high;
    logic [SUM_W-1:0] w_try;

    assign w_m01  = (i_mag[0] > i_mag[1]) ? i_mag[0] : i_mag[1];
    assign w_max  = (w_m01 > i_mag[2]) ? w_m01 : i_mag[2];
    assign w_high = r_m[MAG_W-1:SCALE_LO+1] != '0;
    assign w_try  = r_root + r_bit;

    always_ff @(posedge i_clk) begin
        case (i_op)
            NM_MAX: begin
                r_m <= w_max;
                r_p <= '0;
            end
            NM_SCALE: begin
                if (w_high) begin
                    r_m <= r_m >> 1;
                    r_p <= r_p - SH_W'(1);
                end else if (!r_m[SCALE_LO]) begin
                    r_m <= r_m << 1;
                    r_p <= r_p + SH_W'(1);
                end
            end
            NM_SUM: begin
                r_rad  <= SUM_W'(i_sq[0]) + SUM_W'(i_sq[1]) + SUM_W'(i_sq[2]);
                r_root <= '0;
                r_bit  <= SUM_W'(1) << (SUM_W - 2);
            end
            NM_STEP: begin
                if (r_rad >= w_try) begin
                    r_rad  <= r_rad - w_try;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            default: begin
            end
        endcase
    end

    assign o_zero   = r_m == '0;
    assign o_scaled = !w_high && r_m[SCALE_LO];
    assign o_p      = r_p;
    assign o_root   = DIV_W'(r_root);

endmodule

### src/vertex_attribute_interpolator.sv
// Blends a vertex attribute over a run of transactions, one per vertex, and emits one
// result on the transaction with tlast set. Position, screen position and texture
// items step through accept, two half multiplies, product rounding, saturating add
// and finish; a final item then goes on to output. In a normal item the xyz magnitude
// is scaled one bit a cycle (up to 29 steps), the shared merge unit takes a 31-step
// square root, and the four lanes divide in parallel in 64 steps; a final normal item
// runs that normalization twice, once for its own vector and once for the blended sum.
// The result sits in an output register, so a new transaction is taken while it waits.
module vertex_attribute_interpolator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // weight, comp_x, comp_y, comp_z, comp_w
    input  logic [vai_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // kind
    input  logic [1:0]                        i_s_axis_tuser,
    input  logic                              i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // out_x, out_y, out_z, out_w
    output logic [vai_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // out_kind, degenerate
    output logic [2:0]                        o_m_axis_tuser
);
    `include "vertex_attribute_interpolator_defines.svh"
    import vai_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_MAX   = 5'd1;
    localparam logic [4:0] S_CHK   = 5'd2;
    localparam logic [4:0] S_SCALE = 5'd3;
    localparam logic [4:0] S_SQS   = 5'd4;
    localparam logic [4:0] S_SQM   = 5'd5;
    localparam logic [4:0] S_SUM   = 5'd6;
    localparam logic [4:0] S_SQRT  = 5'd7;
    localparam logic [4:0] S_DIVI  = 5'd8;
    localparam logic [4:0] S_DIV   = 5'd9;
    localparam logic [4:0] S_DIVE  = 5'd10;
    localparam logic [4:0] S_MLO   = 5'd11;
    localparam logic [4:0] S_MHI   = 5'd12;
    localparam logic [4:0] S_TERM  = 5'd13;
    localparam logic [4:0] S_ACC   = 5'd14;
    localparam logic [4:0] S_FIN   = 5'd15;
    localparam logic [4:0] S_OUT   = 5'd16;

    logic [4:0]                   r_state, n_state;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic                         r_final;
    logic                         r_zero_seen;
    logic                         r_norm_zero;
    logic                         r_out_valid;
    logic [1:0]                   r_kind;
    logic                         r_last;
    logic signed [DATA_WIDTH-1:0] r_weight;
    logic [OUT_TDATA_W-1:0]       r_out_data;
    logic [1:0]                   r_out_kind;
    logic                         r_out_degen;

    t_lane_ctl                    w_ctl;
    logic [2:0]                   w_nm_op;
    logic                         w_in_fire;
    logic                         w_out_load;
    logic                         w_degen;
    logic [3:0][MAG_W-1:0]        w_mag_all;
    logic [3:0][SQ_W-1:0]         w_sq_all;
    logic [3:0][ACC_W-1:0]        w_value;
    logic [3:0][DATA_WIDTH-1:0]   w_lane_in;
    logic                         w_zero;
    logic                         w_scaled;
    logic signed [SH_W-1:0]       w_p;
    logic [DIV_W-1:0]             w_root;
    logic [4*DATA_WIDTH-1:0]      w_out_bits;

    assign o_s_axis_tready = r_state == S_IDLE;
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_load      = (r_state == S_OUT) && (!r_out_valid || i_m_axis_tready);
    assign w_degen         = r_zero_seen || r_norm_zero;

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_lane
            // texture coordinates carry no z and w
            if (g >= 2) begin : g_tex
                assign w_lane_in[g] = (i_s_axis_tuser == KIND_TEX) ? '0
                                    : i_s_axis_tdata[(g+1)*DATA_WIDTH +: DATA_WIDTH];
            end else begin : g_plain
                assign w_lane_in[g] = i_s_axis_tdata[(g+1)*DATA_WIDTH +: DATA_WIDTH];
            end

            vai_lane u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_data   (w_lane_in[g]),
                .i_weight (r_weight),
                .i_div    (w_root),
                .o_mag    (w_mag_all[g]),
                .o_sq     (w_sq_all[g]),
                .o_value  (w_value[g])
            );

            assign w_out_bits[g*DATA_WIDTH +: DATA_WIDTH] =
                w_degen ? '0 : sat_data(w_value[g]);
        end
    endgenerate

    vai_norm u_norm (
        .i_clk    (i_clk),
        .i_op     (w_nm_op),
        .i_mag    (w_mag_all[2:0]),
        .i_sq     (w_sq_all[2:0]),
        .o_zero   (w_zero),
        .o_scaled (w_scaled),
        .o_p      (w_p),
        .o_root   (w_root)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        w_ctl.op    = LN_HOLD;
        w_ctl.shift = w_p;
        w_nm_op     = NM_HOLD;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    w_ctl.op = LN_LOAD_IN;
                    n_state  = (i_s_axis_tuser == KIND_NORMAL) ? S_MAX : S_MLO;
                end
            end
            S_MAX: begin
                w_nm_op = NM_MAX;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (w_zero) begin
                    n_state = r_final ? S_OUT : S_FIN;
                end else begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                if (w_scaled) begin
                    n_state = S_SQS;
                end else begin
                    w_nm_op = NM_SCALE;
                end
            end
            S_SQS: begin
                w_ctl.op = LN_SQ_SHIFT;
                n_state  = S_SQM;
            end
            S_SQM: begin
                w_ctl.op = LN_SQ_MUL;
                n_state  = S_SUM;
            end
            S_SUM: begin
                w_nm_op = NM_SUM;
                n_cnt   = CNT_W'(ROOT_STEPS - 1);
                n_state = S_SQRT;
            end
            S_SQRT: begin
                w_nm_op = NM_STEP;
                if (r_cnt == '0) begin
                    n_state = S_DIVI;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_DIVI: begin
                w_ctl.op    = LN_DIV_INIT;
                w_ctl.shift = w_p + SH_W'(FRAC_BITS);
                n_cnt       = CNT_W'(QUO_W - 1);
                n_state     = S_DIV;
            end
            S_DIV: begin
                w_ctl.op = LN_DIV_STEP;
                if (r_cnt == '0) begin
                    n_state = S_DIVE;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_DIVE: begin
                w_ctl.op = LN_DIV_END;
                n_state  = r_final ? S_OUT : S_MLO;
            end
            S_MLO: begin
                w_ctl.op = LN_MUL_LO;
                n_state  = S_MHI;
            end
            S_MHI: begin
                w_ctl.op = LN_MUL_HI;
                n_state  = S_TERM;
            end
            S_TERM: begin
                w_ctl.op = LN_TERM;
                n_state  = S_ACC;
            end
            S_ACC: begin
                w_ctl.op = LN_ACC;
                n_state  = S_FIN;
            end
            S_FIN: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else begin
                    w_ctl.op = LN_LOAD_ACC;
                    n_state  = (r_kind == KIND_NORMAL) ? S_MAX : S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    w_ctl.op = LN_CLEAR;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_final     <= 1'b0;
            r_zero_seen <= 1'b0;
            r_norm_zero <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_in_fire) begin
                r_final <= 1'b0;
            end else if (r_state == S_FIN && r_last) begin
                r_final <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_zero_seen <= 1'b0;
                r_norm_zero <= 1'b0;
            end else begin
                if (i_m_axis_tready) begin
                    r_out_valid <= 1'b0;
                end
                if (r_state == S_CHK && w_zero) begin
                    if (r_final) begin
                        r_norm_zero <= 1'b1;
                    end else begin
                        r_zero_seen <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_kind   <= i_s_axis_tuser;
            r_last   <= i_s_axis_tlast;
            r_weight <= i_s_axis_tdata[DATA_WIDTH-1:0];
        end
        if (w_out_load) begin
            r_out_data  <= OUT_TDATA_W'(w_out_bits);
            r_out_kind  <= r_kind;
            r_out_degen <= w_degen;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = {r_out_degen, r_out_kind};

    `VAI_ASSERT_IMPL(a_degen_zero, r_out_valid && r_out_degen, r_out_data == '0)
    `VAI_ASSERT_NEXT(a_item_busy, w_in_fire, r_state != S_IDLE)
    `VAI_ASSERT_IMPL(a_div_norm, r_state == S_DIV, w_root[DIV_W-1:SCALE_LO] != '0)
    `VAI_ASSERT_NEXT(a_out_load, w_out_load, r_out_valid)

endmodule
